FILE: src/lafc_pkg.sv
`timescale 1ns / 1ps

package lafc_pkg;

    // Charge phases
    localparam logic [1:0] PH_CC    = 2'd0;
    localparam logic [1:0] PH_PAUSE = 2'd1;
    localparam logic [1:0] PH_CV    = 2'd2;
    localparam logic [1:0] PH_REST  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_VOLTAGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CURRENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_MINUTES = 3'd4;
    localparam int CFG_DATA_W = 15;

    // Fixed constants, mV / mA / s / ms
    localparam logic [15:0] SETTLE_S         = 16'd10;
    localparam logic [15:0] TRIP_PER_CELL_MV = 16'd50;
    localparam logic [14:0] HOLD_BAND_MV     = 15'd20;
    localparam logic [2:0]  DONE_COUNT       = 3'd5;
    localparam logic [15:0] DOWN_GAP_MS      = 16'd300;
    localparam logic [13:0] FLOOR_MIN_MA     = 14'd10;
    localparam logic [13:0] SEC_PER_MIN      = 14'd60;

    // Reset values of the registers
    localparam logic [14:0] RST_END_VOLTAGE  = 15'd13650;
    localparam logic [13:0] RST_MAX_CURRENT  = 14'd1000;
    localparam logic [13:0] RST_MIN_CURRENT  = 14'd100;
    localparam logic [4:0]  RST_CELL_COUNT   = 5'd6;
    localparam logic [7:0]  RST_REST_MINUTES = 8'd5;

    // ceil(2^15 / 10); exact quotient for every 14-bit dividend
    localparam logic [11:0] RECIP10 = 12'd3277;

    typedef struct packed {
        logic [14:0] end_voltage;
        logic [13:0] max_current;
        logic [13:0] min_current;
        logic [4:0]  cell_count;
        logic [7:0]  rest_minutes;
    } t_cfg;

    typedef struct packed {
        logic [15:0] battery_mv;
        logic        sample_stable;
        logic [15:0] time_ms;
        logic [15:0] time_s;
    } t_in_item;

    typedef struct packed {
        logic        drive_enable;
        logic [13:0] current_setpoint;
        logic [15:0] cutoff_voltage;
        logic [1:0]  phase;
        logic        status;
    } t_out_item;

    // x / 10 for a 14-bit x by reciprocal multiply
    function automatic logic [10:0] div10(input logic [13:0] x);
        logic [25:0] prod;
        prod = 26'(x) * 26'(RECIP10);
        return prod[25:15];
    endfunction

endpackage

FILE: src/lafc_if.sv
`timescale 1ns / 1ps

interface lafc_in_if;
    logic                 valid;
    logic                 ready;
    lafc_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lafc_out_if;
    logic                 valid;
    logic                 ready;
    lafc_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lafc_core.sv
`timescale 1ns / 1ps

module lafc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  lafc_pkg::t_in_item  i_item,
    input  lafc_pkg::t_cfg      i_cfg,
    output lafc_pkg::t_out_item o_result
);

    logic [1:0]  r_phase,       n_phase;
    logic [15:0] r_pause_start, n_pause_start;
    logic [13:0] r_current,     n_current;
    logic [15:0] r_trip,        n_trip;
    logic [13:0] r_floor,       n_floor;
    logic [2:0]  r_hold,        n_hold;
    logic [15:0] r_last_step,   n_last_step;
    logic [15:0] r_rest_start,  n_rest_start;
    logic        r_err,         n_err;

    logic [15:0] pause_dt, step_dt, rest_dt;
    logic [13:0] rest_len;
    logic [13:0] excess;
    logic [10:0] q, step;
    logic [14:0] dn_lim, up_sum;
    logic [15:0] end_v16;
    logic [10:0] min_q;
    logic [13:0] floor_new;
    logic [15:0] trip_new;
    logic        drive;

    always_comb begin
        pause_dt  = i_item.time_s - r_pause_start;
        step_dt   = i_item.time_ms - r_last_step;
        rest_dt   = i_item.time_s - r_rest_start;
        rest_len  = 14'(i_cfg.rest_minutes) * lafc_pkg::SEC_PER_MIN;
        excess    = (r_current > r_floor) ? (r_current - r_floor) : 14'd0;
        q         = lafc_pkg::div10(excess);
        step      = (q == 11'd0) ? 11'd1 : q;
        dn_lim    = {1'b0, r_floor} + 15'(step);
        up_sum    = {1'b0, r_current} + 15'(step);
        end_v16   = {1'b0, i_cfg.end_voltage};
        min_q     = lafc_pkg::div10(i_cfg.min_current);
        floor_new = (14'(min_q) < lafc_pkg::FLOOR_MIN_MA) ? lafc_pkg::FLOOR_MIN_MA
                                                           : 14'(min_q);
        trip_new  = end_v16 + 16'(i_cfg.cell_count) * lafc_pkg::TRIP_PER_CELL_MV;
    end

    always_comb begin
        n_phase       = r_phase;
        n_pause_start = r_pause_start;
        n_current     = r_current;
        n_trip        = r_trip;
        n_floor       = r_floor;
        n_hold        = r_hold;
        n_last_step   = r_last_step;
        n_rest_start  = r_rest_start;
        n_err         = r_err;
        if (!r_err) begin
            case (r_phase)
                lafc_pkg::PH_CC: begin
                    if (i_item.battery_mv >= end_v16) begin
                        n_pause_start = i_item.time_s;
                        n_phase       = lafc_pkg::PH_PAUSE;
                    end
                end
                lafc_pkg::PH_PAUSE: begin
                    if (pause_dt >= lafc_pkg::SETTLE_S) begin
                        n_trip      = trip_new;
                        n_floor     = floor_new;
                        n_current   = floor_new;
                        n_hold      = 3'd0;
                        n_last_step = i_item.time_ms;
                        n_phase     = lafc_pkg::PH_CV;
                    end
                end
                lafc_pkg::PH_CV: begin
                    if (i_item.battery_mv > r_trip) begin
                        n_err = 1'b1;
                    end else if (i_item.battery_mv > end_v16) begin
                        // step down, rate limited
                        if (step_dt >= lafc_pkg::DOWN_GAP_MS) begin
                            n_last_step = i_item.time_ms;
                            n_hold      = 3'd0;
                            n_current   = ({1'b0, r_current} >= dn_lim)
                                          ? (r_current - 14'(step)) : r_floor;
                        end
                    end else if (i_item.sample_stable) begin
                        if (i_cfg.end_voltage >= lafc_pkg::HOLD_BAND_MV &&
                            i_item.battery_mv <
                                16'(i_cfg.end_voltage - lafc_pkg::HOLD_BAND_MV)) begin
                            n_last_step = i_item.time_ms;
                            n_hold      = 3'd0;
                            n_current   = (up_sum <= {1'b0, i_cfg.max_current})
                                          ? up_sum[13:0] : i_cfg.max_current;
                        end else if (r_current <= r_floor) begin
                            n_hold = r_hold + 3'd1;
                            if (n_hold >= lafc_pkg::DONE_COUNT) begin
                                n_rest_start = i_item.time_s;
                                n_phase      = lafc_pkg::PH_REST;
                            end
                        end else begin
                            n_hold = 3'd0;
                        end
                    end
                end
                default: begin
                    if (rest_dt >= 16'(rest_len)) begin
                        n_phase = lafc_pkg::PH_CC;
                    end
                end
            endcase
        end
    end

    // result reflects the state after this step
    always_comb begin
        drive = !n_err && (n_phase == lafc_pkg::PH_CC || n_phase == lafc_pkg::PH_CV);
        o_result.drive_enable     = drive;
        o_result.current_setpoint = !drive ? 14'd0
                                  : (n_phase == lafc_pkg::PH_CC) ? i_cfg.max_current
                                  : n_current;
        o_result.cutoff_voltage   = n_trip;
        o_result.phase            = n_phase;
        o_result.status           = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lafc_pkg::PH_CC;
            r_pause_start <= 16'd0;
            r_current     <= 14'd0;
            r_trip        <= 16'd0;
            r_floor       <= lafc_pkg::FLOOR_MIN_MA;
            r_hold        <= 3'd0;
            r_last_step   <= 16'd0;
            r_rest_start  <= 16'd0;
            r_err         <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_pause_start <= n_pause_start;
            r_current     <= n_current;
            r_trip        <= n_trip;
            r_floor       <= n_floor;
            r_hold        <= n_hold;
            r_last_step   <= n_last_step;
            r_rest_start  <= n_rest_start;
            r_err         <= n_err;
        end
    end

endmodule

FILE: src/lead_acid_float_charge_controller_unit.sv
`timescale 1ns / 1ps

// Lead-acid CC / pause / CV float charger, one step per converter sample.
// Channels:
//   i_in  : sample beat {battery_mv, sample_stable, time_ms, time_s}.
//   o_out : result beat {drive_enable, current_setpoint, cutoff_voltage,
//           phase, status}, one per sample, in order.
//   i_cfg_*: register write port, index per register list, no read-back.
//            Write only while no sample is in flight.
// Path: a sample accepted on i_in passes the input register, then one pass
//   of step logic into the result register, which presents it on o_out.
// Throughput: one sample per cycle unless o_out stalls; single-pass step
//   logic, 14x12 reciprocal multiplies for the /10 step size and float floor.
// Stall: when o_out.ready is low the result register holds, the input
//   register fills, and i_in.ready drops once both are occupied.
// Reset (i_rst_n low, synchronous): pipeline empties, charger state goes
//   to constant current with no error, registers take their defaults.
// An over-voltage trip in CV latches status=1 with drive off until reset.

module lead_acid_float_charge_controller_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lafc_in_if.sink                            i_in,
    lafc_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [lafc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lafc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lafc_pkg::t_cfg      r_cfg;
    lafc_pkg::t_in_item  r_in;
    logic                r_in_vld;
    lafc_pkg::t_out_item r_out;
    logic                r_out_vld;
    lafc_pkg::t_out_item step_res;
    logic                advance;

    // step fires when a sample is held and the result slot is free or draining
    assign advance     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || advance;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.end_voltage  <= lafc_pkg::RST_END_VOLTAGE;
            r_cfg.max_current  <= lafc_pkg::RST_MAX_CURRENT;
            r_cfg.min_current  <= lafc_pkg::RST_MIN_CURRENT;
            r_cfg.cell_count   <= lafc_pkg::RST_CELL_COUNT;
            r_cfg.rest_minutes <= lafc_pkg::RST_REST_MINUTES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lafc_pkg::CFG_END_VOLTAGE:  r_cfg.end_voltage  <= i_cfg_data[14:0];
                lafc_pkg::CFG_MAX_CURRENT:  r_cfg.max_current  <= i_cfg_data[13:0];
                lafc_pkg::CFG_MIN_CURRENT:  r_cfg.min_current  <= i_cfg_data[13:0];
                lafc_pkg::CFG_CELL_COUNT:   r_cfg.cell_count   <= i_cfg_data[4:0];
                lafc_pkg::CFG_REST_MINUTES: r_cfg.rest_minutes <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    lafc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

endmodule
